// ===== hw/rtl/etg_pkg.sv =====
package etg_pkg;

    localparam int ANG_W = 32;
    localparam int FB    = 30;
    localparam int ITERS = FB;
    localparam int CW    = 36;
    localparam int PW    = 2 * CW;

    localparam logic signed [CW-1:0] HALF_TURN    = 36'sh0_8000_0000;
    localparam logic signed [CW-1:0] QUARTER_TURN = 36'sh0_4000_0000;

    localparam longint K_Q62 = 64'sd2800459870029452959;
    localparam logic signed [CW-1:0] KF = CW'((K_Q62 + 64'sd2147483648) >>> 32);

    localparam longint DEN = 64'sd1000000000000;

    localparam logic signed [PW-1:0] RND_UP = PW'(64'sd1 <<< (FB - 1));
    localparam logic signed [PW-1:0] RND_DN = RND_UP - PW'(1);

    localparam logic signed [CW-1:0] ATAN_TBL [ITERS] = '{
        36'sd536870912, 36'sd316933406, 36'sd167458907, 36'sd85004756,
        36'sd42667331,  36'sd21354465,  36'sd10679838,  36'sd5340245,
        36'sd2670163,   36'sd1335087,   36'sd667544,    36'sd333772,
        36'sd166886,    36'sd83443,     36'sd41722,     36'sd20861,
        36'sd10430,     36'sd5215,      36'sd2608,      36'sd1304,
        36'sd652,       36'sd326,       36'sd163,       36'sd81,
        36'sd41,        36'sd20,        36'sd10,        36'sd5,
        36'sd3,         36'sd1
    };

    function automatic logic signed [CW-1:0] coef_q(input longint num);
        longint r;
        longint q;
        logic   neg;
        int     i;
        neg = (num < 0);
        r   = neg ? -num : num;
        q   = 0;
        for (i = 0; i < FB; i++) begin
            r = r * 2;
            q = q * 2;
            if (r >= DEN) begin
                r = r - DEN;
                q = q + 1;
            end
        end
        if (2 * r >= DEN) begin
            q = q + 1;
        end
        return CW'(neg ? -q : q);
    endfunction

    localparam logic signed [CW-1:0] MAT [9] = '{
        coef_q(-64'sd54875539726),  coef_q(-64'sd873437108010), coef_q(-64'sd483834985808),
        coef_q(64'sd494109453312),  coef_q(-64'sd444829589425), coef_q(64'sd746982251810),
        coef_q(-64'sd867666135858), coef_q(-64'sd198076386122), coef_q(64'sd455983795705)
    };

    function automatic logic signed [CW-1:0] fx_round(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = p + (p[PW-1] ? RND_DN : RND_UP);
        return CW'(s >>> FB);
    endfunction

endpackage

// ===== hw/rtl/etg_rot_cordic.sv =====
module etg_rot_cordic
    import etg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ce,
    input  logic                 in_valid,
    input  logic [ANG_W-1:0]     angle,
    output logic                 out_valid,
    output logic signed [CW-1:0] cos_out,
    output logic signed [CW-1:0] sin_out
);

    logic                 v_reg   [ITERS+1];
    logic                 neg_reg [ITERS+1];
    logic signed [CW-1:0] x_reg   [ITERS+1];
    logic signed [CW-1:0] y_reg   [ITERS+1];
    logic signed [CW-1:0] t_reg   [ITERS+1];
    logic                 out_v_reg;
    logic signed [CW-1:0] cos_reg;
    logic signed [CW-1:0] sin_reg;

    logic signed [CW-1:0] t_in;
    logic signed [CW-1:0] t_next;
    logic                 neg_next;

    assign t_in = {{(CW-ANG_W){angle[ANG_W-1]}}, angle};

    always_comb begin
        t_next   = t_in;
        neg_next = 1'b0;
        if (t_in > QUARTER_TURN) begin
            t_next   = t_in - HALF_TURN;
            neg_next = 1'b1;
        end else if (t_in < -QUARTER_TURN) begin
            t_next   = t_in + HALF_TURN;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= ITERS; i++) begin
                v_reg[i] <= 1'b0;
            end
            out_v_reg <= 1'b0;
        end else if (ce) begin
            v_reg[0] <= in_valid;
            for (int i = 0; i < ITERS; i++) begin
                v_reg[i+1] <= v_reg[i];
            end
            out_v_reg <= v_reg[ITERS];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg[0]   <= KF;
            y_reg[0]   <= '0;
            t_reg[0]   <= t_next;
            neg_reg[0] <= neg_next;
            for (int i = 0; i < ITERS; i++) begin
                neg_reg[i+1] <= neg_reg[i];
                if (!t_reg[i][CW-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    t_reg[i+1] <= t_reg[i] - ATAN_TBL[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    t_reg[i+1] <= t_reg[i] + ATAN_TBL[i];
                end
            end
            cos_reg <= neg_reg[ITERS] ? -x_reg[ITERS] : x_reg[ITERS];
            sin_reg <= neg_reg[ITERS] ? -y_reg[ITERS] : y_reg[ITERS];
        end
    end

    assign out_valid = out_v_reg;
    assign cos_out   = cos_reg;
    assign sin_out   = sin_reg;

endmodule

// ===== hw/rtl/etg_vec_cordic.sv =====
module etg_vec_cordic
    import etg_pkg::*;
#(
    parameter int AUX_W = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ce,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic [AUX_W-1:0]     aux_in,
    output logic                 out_valid,
    output logic signed [CW-1:0] z_out,
    output logic signed [CW-1:0] mag_out,
    output logic                 zero_out,
    output logic [AUX_W-1:0]     aux_out
);

    logic                 v_reg    [ITERS+1];
    logic                 zero_reg [ITERS+1];
    logic [AUX_W-1:0]     aux_reg  [ITERS+1];
    logic signed [CW-1:0] x_reg    [ITERS+1];
    logic signed [CW-1:0] y_reg    [ITERS+1];
    logic signed [CW-1:0] z_reg    [ITERS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= ITERS; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (ce) begin
            v_reg[0] <= in_valid;
            for (int i = 0; i < ITERS; i++) begin
                v_reg[i+1] <= v_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            aux_reg[0]  <= aux_in;
            if (x_in[CW-1]) begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= HALF_TURN;
            end else begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
            for (int i = 0; i < ITERS; i++) begin
                zero_reg[i+1] <= zero_reg[i];
                aux_reg[i+1]  <= aux_reg[i];
                if (!y_reg[i][CW-1] && (y_reg[i] != '0)) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TBL[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TBL[i];
                end
            end
        end
    end

    assign out_valid = v_reg[ITERS];
    assign z_out     = z_reg[ITERS];
    assign mag_out   = x_reg[ITERS];
    assign zero_out  = zero_reg[ITERS];
    assign aux_out   = aux_reg[ITERS];

endmodule

// ===== hw/rtl/etg_mat.sv =====
module etg_mat
    import etg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ce,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] cos_ra,
    input  logic signed [CW-1:0] sin_ra,
    input  logic signed [CW-1:0] cos_dec,
    input  logic signed [CW-1:0] sin_dec,
    output logic                 out_valid,
    output logic signed [CW-1:0] vx,
    output logic signed [CW-1:0] vy,
    output logic signed [CW-1:0] vz
);

    logic [4:0]           v_reg;
    logic signed [PW-1:0] pa_reg;
    logic signed [PW-1:0] pb_reg;
    logic signed [CW-1:0] sd_reg;
    logic signed [CW-1:0] v1_reg   [3];
    logic signed [PW-1:0] prod_reg [9];
    logic signed [CW-1:0] term_reg [9];
    logic signed [CW-1:0] v2_reg   [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            pa_reg    <= cos_dec * cos_ra;
            pb_reg    <= cos_dec * sin_ra;
            sd_reg    <= sin_dec;
            v1_reg[0] <= fx_round(pa_reg);
            v1_reg[1] <= fx_round(pb_reg);
            v1_reg[2] <= sd_reg;
            for (int k = 0; k < 9; k++) begin
                prod_reg[k] <= MAT[k] * v1_reg[k % 3];
                term_reg[k] <= fx_round(prod_reg[k]);
            end
            for (int r = 0; r < 3; r++) begin
                v2_reg[r] <= term_reg[3*r] + term_reg[3*r+1] + term_reg[3*r+2];
            end
        end
    end

    assign out_valid = v_reg[4];
    assign vx        = v2_reg[0];
    assign vy        = v2_reg[1];
    assign vz        = v2_reg[2];

endmodule

// ===== hw/rtl/equatorial_to_galactic_rotation.sv =====
// Channel | Fields (lowest bit up)                        | Width
// s_      | ra_angle [31:0], dec_angle [63:32]            | 64
// m_      | gal_lon [31:0], gal_lat [63:32]               | 64
//
// One word in, one word out per cycle while m_ does not stall, through the
// 30-step ra/dec rotation CORDICs, the matrix multiply stages, the lon vectoring
// CORDIC, two magnitude scaling stages, the lat CORDIC and the output register.
// aresetn clears every valid bit; payload registers are not reset.
// A stall on m_ freezes the whole pipeline; s_tready drops while a result waits
// and during reset.
module equatorial_to_galactic_rotation
    import etg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // ra_angle [31:0], dec_angle [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // gal_lon [31:0], gal_lat [63:32]
);

    logic                 ce;
    logic                 in_valid;

    logic                 ra_valid;
    logic                 dec_valid;
    logic signed [CW-1:0] cos_ra;
    logic signed [CW-1:0] sin_ra;
    logic signed [CW-1:0] cos_dec;
    logic signed [CW-1:0] sin_dec;

    logic                 mat_valid;
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic signed [CW-1:0] vz;

    logic                 lon_valid;
    logic signed [CW-1:0] lon_z;
    logic signed [CW-1:0] lon_mag;
    logic                 lon_zero;
    logic [CW-1:0]        lon_aux;

    logic [1:0]           r_v_reg;
    logic signed [PW-1:0] rk_p_reg;
    logic [ANG_W-1:0]     lon1_reg;
    logic signed [CW-1:0] vz1_reg;
    logic signed [CW-1:0] rk_reg;
    logic [ANG_W-1:0]     lon2_reg;
    logic signed [CW-1:0] vz2_reg;

    logic                 lat_valid;
    logic signed [CW-1:0] lat_z;
    logic signed [CW-1:0] lat_mag;
    logic                 lat_zero;
    logic [ANG_W-1:0]     lat_aux;
    logic signed [CW-1:0] lat_next;

    logic                 m_tvalid_reg;
    logic [63:0]          m_tdata_reg;

    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce && aresetn;
    assign in_valid = s_tvalid && s_tready;

    etg_rot_cordic u_rot_ra (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (in_valid),
        .angle     (s_tdata[31:0]),
        .out_valid (ra_valid),
        .cos_out   (cos_ra),
        .sin_out   (sin_ra)
    );

    etg_rot_cordic u_rot_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (in_valid),
        .angle     (s_tdata[63:32]),
        .out_valid (dec_valid),
        .cos_out   (cos_dec),
        .sin_out   (sin_dec)
    );

    etg_mat u_mat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (ra_valid && dec_valid),
        .cos_ra    (cos_ra),
        .sin_ra    (sin_ra),
        .cos_dec   (cos_dec),
        .sin_dec   (sin_dec),
        .out_valid (mat_valid),
        .vx        (vx),
        .vy        (vy),
        .vz        (vz)
    );

    etg_vec_cordic #(.AUX_W(CW)) u_vec_lon (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (mat_valid),
        .x_in      (vx),
        .y_in      (vy),
        .aux_in    (vz),
        .out_valid (lon_valid),
        .z_out     (lon_z),
        .mag_out   (lon_mag),
        .zero_out  (lon_zero),
        .aux_out   (lon_aux)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_v_reg <= '0;
        end else if (ce) begin
            r_v_reg <= {r_v_reg[0], lon_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rk_p_reg <= lon_mag * KF;
            lon1_reg <= lon_zero ? '0 : lon_z[ANG_W-1:0];
            vz1_reg  <= lon_aux;
            rk_reg   <= fx_round(rk_p_reg);
            lon2_reg <= lon1_reg;
            vz2_reg  <= vz1_reg;
        end
    end

    etg_vec_cordic #(.AUX_W(ANG_W)) u_vec_lat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (r_v_reg[1]),
        .x_in      (rk_reg),
        .y_in      (vz2_reg),
        .aux_in    (lon2_reg),
        .out_valid (lat_valid),
        .z_out     (lat_z),
        .mag_out   (lat_mag),
        .zero_out  (lat_zero),
        .aux_out   (lat_aux)
    );

    always_comb begin
        lat_next = lat_z;
        if (lat_zero) begin
            lat_next = '0;
        end else if (lat_z > QUARTER_TURN) begin
            lat_next = QUARTER_TURN;
        end else if (lat_z < -QUARTER_TURN) begin
            lat_next = -QUARTER_TURN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= lat_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= {lat_next[ANG_W-1:0], lat_aux};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
